// ===== hw/rtl/calclk_pkg.sv =====
// Shared widths, reset values, operation codes and calendar helpers for the
// calendar clock with prescaler. No dependencies; every other file uses it.
package calclk_pkg;

   localparam int TICKS_PER_SECOND = 100;
   localparam int PRESCALE_W       = $clog2(TICKS_PER_SECOND);

   localparam int SEC_W   = 6;
   localparam int MIN_W   = 6;
   localparam int HOUR_W  = 5;
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register index, taken from the word address bit of paddr
   typedef enum logic [0:0] {
      CSR_IDX_CLOCK_ENABLE = 1'b0
   } csr_idx_type;

   typedef enum logic [0:0] {
      OP_TICK = 1'b0,
      OP_LOAD = 1'b1
   } op_type;

   localparam logic [SEC_W:0]    SEC_LIMIT   = (SEC_W+1)'(60);
   localparam logic [MIN_W:0]    MIN_LIMIT   = (MIN_W+1)'(60);
   localparam logic [HOUR_W:0]   HOUR_LIMIT  = (HOUR_W+1)'(24);
   localparam logic [MONTH_W:0]  MONTH_LAST  = (MONTH_W+1)'(12);
   localparam logic [YEAR_W:0]   YEAR_LAST   = (YEAR_W+1)'(9999);

   localparam logic [SEC_W-1:0]   RESET_SECOND = '0;
   localparam logic [MIN_W-1:0]   RESET_MINUTE = '0;
   localparam logic [HOUR_W-1:0]  RESET_HOUR   = '0;
   localparam logic [DAY_W-1:0]   RESET_DAY    = DAY_W'(1);
   localparam logic [MONTH_W-1:0] RESET_MONTH  = MONTH_W'(1);
   localparam logic [YEAR_W-1:0]  RESET_YEAR   = YEAR_W'(1980);

   // Gregorian leap rule. y / 100 comes from a reciprocal multiply
   // (5243 / 2^19), exact over the whole 14-bit range.
   function automatic logic leap_year(input logic [YEAR_W-1:0] y);
      logic [26:0] prod;
      logic [7:0]  q100;
      logic [YEAR_W:0] back;
      prod = 27'(y) * 27'(5243);
      q100 = prod[26:19];
      back = (YEAR_W+1)'({q100, 6'b0}) + (YEAR_W+1)'({q100, 5'b0})
           + (YEAR_W+1)'({q100, 2'b0});
      return (y[1:0] == 2'b00) &&
             ((back != {1'b0, y}) || (q100[1:0] == 2'b00));
   endfunction

   // Month outside 1..12 counts as 31 days
   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [DAY_W-1:0] d;
      unique case (m)
         4'd2:                      d = leap ? DAY_W'(29) : DAY_W'(28);
         4'd4, 4'd6, 4'd9, 4'd11:   d = DAY_W'(30);
         default:                   d = DAY_W'(31);
      endcase
      return d;
   endfunction

   localparam logic RESET_LEAP = leap_year(RESET_YEAR);

endpackage

// ===== hw/rtl/calclk_chan_if.sv =====
// Valid/ready channel interfaces for request and response beats.
// Depends on calclk_pkg for field widths and the operation code.
interface calclk_req_if;
   logic                            valid;
   logic                            ready;
   calclk_pkg::op_type              operation;
   logic [calclk_pkg::SEC_W-1:0]    load_second;
   logic [calclk_pkg::MIN_W-1:0]    load_minute;
   logic [calclk_pkg::HOUR_W-1:0]   load_hour;
   logic [calclk_pkg::DAY_W-1:0]    load_day;
   logic [calclk_pkg::MONTH_W-1:0]  load_month;
   logic [calclk_pkg::YEAR_W-1:0]   load_year;

   modport source (
      output valid, operation, load_second, load_minute, load_hour,
             load_day, load_month, load_year,
      input  ready
   );
   modport sink (
      input  valid, operation, load_second, load_minute, load_hour,
             load_day, load_month, load_year,
      output ready
   );
endinterface

interface calclk_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [calclk_pkg::SEC_W-1:0]    second;
   logic [calclk_pkg::MIN_W-1:0]    minute;
   logic [calclk_pkg::HOUR_W-1:0]   hour;
   logic [calclk_pkg::DAY_W-1:0]    day;
   logic [calclk_pkg::MONTH_W-1:0]  month;
   logic [calclk_pkg::YEAR_W-1:0]   year;
   logic                            second_pulse;

   modport source (
      output valid, second, minute, hour, day, month, year, second_pulse,
      input  ready
   );
   modport sink (
      input  valid, second, minute, hour, day, month, year, second_pulse,
      output ready
   );
endinterface

// ===== hw/rtl/calclk_csr.sv =====
// APB-style register block: holds the internal clock enable.
// Depends on calclk_pkg.
module calclk_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [calclk_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [calclk_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [calclk_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                              csr_pready,
   output logic                              clock_enable
);

   logic enable_ff;
   logic enable_in;
   logic sel_enable;
   logic wr_fire;

   // Word address bit picks the register; byte offset bits are ignored
   assign sel_enable = (calclk_pkg::csr_idx_type'(csr_paddr[2])
                        == calclk_pkg::CSR_IDX_CLOCK_ENABLE);
   assign wr_fire    = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      enable_in = enable_ff;
      if (wr_fire && sel_enable) begin
         enable_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
      end else begin
         enable_ff <= enable_in;
      end
   end

   assign csr_prdata   = sel_enable ? calclk_pkg::CSR_DATA_W'(enable_ff) : '0;
   assign clock_enable = enable_ff;

endmodule

// ===== hw/rtl/calclk_core.sv =====
// Prescaler and calendar datapath: input register, single-pass carry chain,
// result register. Depends on calclk_pkg and the channel interfaces.
module calclk_core (
   input  logic          clock,
   input  logic          reset,
   input  logic          clock_enable,
   calclk_req_if.sink    req_chan,
   calclk_rsp_if.source  rsp_chan
);

   localparam int PW = calclk_pkg::PRESCALE_W;

   // Input register
   logic                            in_valid_ff;
   calclk_pkg::op_type              in_op_ff;
   logic [calclk_pkg::SEC_W-1:0]    in_sec_ff;
   logic [calclk_pkg::MIN_W-1:0]    in_min_ff;
   logic [calclk_pkg::HOUR_W-1:0]   in_hour_ff;
   logic [calclk_pkg::DAY_W-1:0]    in_day_ff;
   logic [calclk_pkg::MONTH_W-1:0]  in_month_ff;
   logic [calclk_pkg::YEAR_W-1:0]   in_year_ff;
   logic                            in_leap_ff;

   // Calendar state
   logic [PW-1:0]                   presc_ff, presc_in;
   logic [calclk_pkg::SEC_W-1:0]    sec_ff, sec_in;
   logic [calclk_pkg::MIN_W-1:0]    min_ff, min_in;
   logic [calclk_pkg::HOUR_W-1:0]   hour_ff, hour_in;
   logic [calclk_pkg::DAY_W-1:0]    day_ff, day_in;
   logic [calclk_pkg::MONTH_W-1:0]  month_ff, month_in;
   logic [calclk_pkg::YEAR_W-1:0]   year_ff, year_in;
   logic                            leap_ff, leap_in;

   // Result register
   logic                            out_valid_ff;
   logic                            out_pulse_ff;
   logic                            pulse_in;
   logic [calclk_pkg::SEC_W-1:0]    out_sec_ff;
   logic [calclk_pkg::MIN_W-1:0]    out_min_ff;
   logic [calclk_pkg::HOUR_W-1:0]   out_hour_ff;
   logic [calclk_pkg::DAY_W-1:0]    out_day_ff;
   logic [calclk_pkg::MONTH_W-1:0]  out_month_ff;
   logic [calclk_pkg::YEAR_W-1:0]   out_year_ff;

   logic advance;
   logic work;
   logic in_ready;

   logic [PW:0]                     presc_inc;
   logic                            tick_done;
   logic [calclk_pkg::SEC_W:0]      sec_inc;
   logic [calclk_pkg::MIN_W:0]      min_inc;
   logic [calclk_pkg::HOUR_W:0]     hour_inc;
   logic [calclk_pkg::DAY_W:0]      day_inc;
   logic [calclk_pkg::MONTH_W:0]    month_inc;
   logic [calclk_pkg::YEAR_W:0]     year_inc;
   logic sec_wrap, min_wrap, hour_wrap, day_wrap, month_wrap, year_wrap;
   logic c_min, c_hour, c_day, c_month, c_year;

   assign advance  = !out_valid_ff || rsp_chan.ready;
   assign work     = in_valid_ff && advance;
   assign in_ready = !in_valid_ff || advance;
   assign req_chan.ready = in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_chan.valid) begin
         in_op_ff    <= req_chan.operation;
         in_sec_ff   <= req_chan.load_second;
         in_min_ff   <= req_chan.load_minute;
         in_hour_ff  <= req_chan.load_hour;
         in_day_ff   <= req_chan.load_day;
         in_month_ff <= req_chan.load_month;
         in_year_ff  <= req_chan.load_year;
         in_leap_ff  <= calclk_pkg::leap_year(req_chan.load_year);
      end
   end

   // Next state: a load of the time fields, or a prescaler step with the carry chain for one second
   always_comb begin
      presc_inc = {1'b0, presc_ff} + (PW+1)'(1);
      tick_done = presc_inc >= (PW+1)'(calclk_pkg::TICKS_PER_SECOND);

      sec_inc   = {1'b0, sec_ff} + (calclk_pkg::SEC_W+1)'(1);
      min_inc   = {1'b0, min_ff} + (calclk_pkg::MIN_W+1)'(1);
      hour_inc  = {1'b0, hour_ff} + (calclk_pkg::HOUR_W+1)'(1);
      day_inc   = {1'b0, day_ff} + (calclk_pkg::DAY_W+1)'(1);
      month_inc = {1'b0, month_ff} + (calclk_pkg::MONTH_W+1)'(1);
      year_inc  = {1'b0, year_ff} + (calclk_pkg::YEAR_W+1)'(1);

      sec_wrap   = sec_inc >= calclk_pkg::SEC_LIMIT;
      min_wrap   = min_inc >= calclk_pkg::MIN_LIMIT;
      hour_wrap  = hour_inc >= calclk_pkg::HOUR_LIMIT;
      day_wrap   = day_inc > {1'b0, calclk_pkg::month_days(month_ff, leap_ff)};
      month_wrap = month_inc > calclk_pkg::MONTH_LAST;
      year_wrap  = year_inc > calclk_pkg::YEAR_LAST;

      c_min   = sec_wrap;
      c_hour  = c_min && min_wrap;
      c_day   = c_hour && hour_wrap;
      c_month = c_day && day_wrap;
      c_year  = c_month && month_wrap;

      presc_in = presc_ff;
      sec_in   = sec_ff;
      min_in   = min_ff;
      hour_in  = hour_ff;
      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      pulse_in = 1'b0;

      if (in_op_ff == calclk_pkg::OP_LOAD) begin
         sec_in   = in_sec_ff;
         min_in   = in_min_ff;
         hour_in  = in_hour_ff;
         day_in   = in_day_ff;
         month_in = in_month_ff;
         year_in  = in_year_ff;
      end else begin
         presc_in = tick_done ? '0 : presc_inc[PW-1:0];
         pulse_in = tick_done;
         if (tick_done && clock_enable) begin
            sec_in = sec_wrap ? '0 : sec_inc[calclk_pkg::SEC_W-1:0];
            if (c_min) begin
               min_in = min_wrap ? '0 : min_inc[calclk_pkg::MIN_W-1:0];
            end
            if (c_hour) begin
               hour_in = hour_wrap ? '0 : hour_inc[calclk_pkg::HOUR_W-1:0];
            end
            if (c_day) begin
               day_in = day_wrap ? calclk_pkg::DAY_W'(1)
                                 : day_inc[calclk_pkg::DAY_W-1:0];
            end
            if (c_month) begin
               month_in = month_wrap ? calclk_pkg::MONTH_W'(1)
                                     : month_inc[calclk_pkg::MONTH_W-1:0];
            end
            if (c_year) begin
               year_in = year_wrap ? '0 : year_inc[calclk_pkg::YEAR_W-1:0];
            end
         end
      end
   end

   // A load brings its leap flag along; otherwise refresh it from the year.
   // The flag follows a year increment in the cycle after it, when the month is January.
   assign leap_in = (work && (in_op_ff == calclk_pkg::OP_LOAD))
                  ? in_leap_ff : calclk_pkg::leap_year(year_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         presc_ff <= '0;
         sec_ff   <= calclk_pkg::RESET_SECOND;
         min_ff   <= calclk_pkg::RESET_MINUTE;
         hour_ff  <= calclk_pkg::RESET_HOUR;
         day_ff   <= calclk_pkg::RESET_DAY;
         month_ff <= calclk_pkg::RESET_MONTH;
         year_ff  <= calclk_pkg::RESET_YEAR;
         leap_ff  <= calclk_pkg::RESET_LEAP;
      end else begin
         leap_ff <= leap_in;
         if (work) begin
            presc_ff <= presc_in;
            sec_ff   <= sec_in;
            min_ff   <= min_in;
            hour_ff  <= hour_in;
            day_ff   <= day_in;
            month_ff <= month_in;
            year_ff  <= year_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (work) begin
         out_pulse_ff <= pulse_in;
         out_sec_ff   <= sec_in;
         out_min_ff   <= min_in;
         out_hour_ff  <= hour_in;
         out_day_ff   <= day_in;
         out_month_ff <= month_in;
         out_year_ff  <= year_in;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.second       = out_sec_ff;
   assign rsp_chan.minute       = out_min_ff;
   assign rsp_chan.hour         = out_hour_ff;
   assign rsp_chan.day          = out_day_ff;
   assign rsp_chan.month        = out_month_ff;
   assign rsp_chan.year         = out_year_ff;
   assign rsp_chan.second_pulse = out_pulse_ff;

`ifndef SYNTH
   a_presc_range: assert property (@(posedge clock) disable iff (reset)
      presc_ff < PW'(calclk_pkg::TICKS_PER_SECOND))
      else $error("prescaler out of range");

   a_load_no_pulse: assert property (@(posedge clock) disable iff (reset)
      (work && (in_op_ff == calclk_pkg::OP_LOAD)) |=> !out_pulse_ff)
      else $error("second pulse on a load beat");

   a_tick_pulse: assert property (@(posedge clock) disable iff (reset)
      (work && (in_op_ff == calclk_pkg::OP_TICK)
       && (presc_ff == PW'(calclk_pkg::TICKS_PER_SECOND - 1)))
      |=> (out_pulse_ff && (presc_ff == '0)))
      else $error("prescaler wrap missed");

   a_leap_after_load: assert property (@(posedge clock) disable iff (reset)
      (work && (in_op_ff == calclk_pkg::OP_LOAD))
      |=> (leap_ff == calclk_pkg::leap_year(year_ff)))
      else $error("leap flag stale after load");
`endif

endmodule

// ===== hw/rtl/calendar_clock_with_prescaler_unit.sv =====
// Calendar clock with prescaler: top level. Depends on calclk_pkg,
// the channel interfaces, calclk_csr and calclk_core.
//
// Each request beat is a 10 ms tick or a time load, and each produces exactly
// one response beat with the calendar after it. The unit takes one beat per
// clock cycle while responses are taken. A request accepted at a clock edge
// sits in the input register. From there it passes the prescaler and the
// second-to-year carry chain into the result register, which holds the
// response valid until it is taken. While a response waits to be taken, the
// request side accepts one more beat into the input register and then holds
// ready low until the response moves. The leap flag for the current year
// sits in a register beside the calendar so that the carry chain never waits
// on the leap computation. Register 0 (byte address 0, bit 0) enables
// calendar advance and resets to 1; the prescaler and second_pulse run
// regardless. Write it only while no beat is in flight.
module calendar_clock_with_prescaler_unit (
   input  logic                              clock,
   input  logic                              reset,
   calclk_req_if.sink                        req_chan,
   calclk_rsp_if.source                      rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [calclk_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [calclk_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [calclk_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                              csr_pready
);

   logic clock_enable;

   calclk_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .clock_enable (clock_enable)
   );

   calclk_core u_core (
      .clock        (clock),
      .reset        (reset),
      .clock_enable (clock_enable),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan)
   );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for calendar_clock_with_prescaler_unit: ticks and time loads with
// random gaps and stalls, each response beat checked against an in-bench calendar.
// Depends on calclk_pkg and the calclk_req_if / calclk_rsp_if channel interfaces.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import calclk_pkg::*;

   localparam int CYCLE_LIMIT  = 600_000;
   localparam int ITEM_TARGET  = 1400;
   localparam int DRAIN_CYCLES = 8;

   localparam logic [CSR_ADDR_W-1:0] ENABLE_ADDR = CSR_ADDR_W'(4 * int'(CSR_IDX_CLOCK_ENABLE));
   // Word 1 holds no register
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR  = CSR_ADDR_W'(4);

   typedef struct packed {
      logic [SEC_W-1:0]   second;
      logic [MIN_W-1:0]   minute;
      logic [HOUR_W-1:0]  hour;
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } cal_fields_type;

   typedef struct packed {
      cal_fields_type fields;
      logic           second_pulse;
   } cal_result_type;

   logic clock = 1'b0;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   calclk_req_if req_bus ();
   calclk_rsp_if rsp_bus ();

   calendar_clock_with_prescaler_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Calendar tracked by the bench
   cal_fields_type cal_now;
   int             tick_count;
   logic           clock_enable;

   cal_result_type expected_times[$];
   int             error_count;
   int             cycle_count;
   int             items_sent;
   int             req_gap_max;
   int             rsp_stall_max;
   int             rsp_hold_cycles;

   function automatic cal_fields_type make_time(int s, int mi, int h, int d, int mo, int y);
      cal_fields_type f;
      f.second = SEC_W'(s);
      f.minute = MIN_W'(mi);
      f.hour   = HOUR_W'(h);
      f.day    = DAY_W'(d);
      f.month  = MONTH_W'(mo);
      f.year   = YEAR_W'(y);
      return f;
   endfunction

   function automatic int days_in(int mo, int y);
      bit leap;
      leap = (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
      case (mo)
         2:             return leap ? 29 : 28;
         4, 6, 9, 11:   return 30;
         default:       return 31;
      endcase
   endfunction

   // Carry one second; sec/min/hour wrap at >= limit, day/month/year at > their last value
   function automatic void step_second();
      int nxt;
      nxt = (int'(cal_now.second) + 1) % 64;
      if (nxt != 0 && nxt < 60) begin
         cal_now.second = SEC_W'(nxt);
         return;
      end
      cal_now.second = '0;
      nxt = int'(cal_now.minute) + 1;
      if (nxt < 60) begin
         cal_now.minute = MIN_W'(nxt);
         return;
      end
      cal_now.minute = '0;
      nxt = int'(cal_now.hour) + 1;
      if (nxt < 24) begin
         cal_now.hour = HOUR_W'(nxt);
         return;
      end
      cal_now.hour = '0;
      nxt = int'(cal_now.day) + 1;
      if (nxt <= days_in(int'(cal_now.month), int'(cal_now.year))) begin
         cal_now.day = DAY_W'(nxt);
         return;
      end
      cal_now.day = DAY_W'(1);
      nxt = int'(cal_now.month) + 1;
      if (nxt <= 12) begin
         cal_now.month = MONTH_W'(nxt);
         return;
      end
      cal_now.month = MONTH_W'(1);
      nxt = int'(cal_now.year) + 1;
      cal_now.year = (nxt > 9999) ? '0 : YEAR_W'(nxt);
   endfunction

   function automatic cal_result_type next_calendar(op_type op, cal_fields_type ld);
      cal_result_type r;
      r.second_pulse = 1'b0;
      if (op == OP_LOAD) begin
         cal_now = ld;
      end else begin
         tick_count++;
         if (tick_count >= TICKS_PER_SECOND) begin
            tick_count = 0;
            r.second_pulse = 1'b1;
            if (clock_enable) step_second();
         end
      end
      r.fields = cal_now;
      return r;
   endfunction

   function automatic cal_fields_type rand_bits_fields();
      cal_fields_type f;
      f.second = SEC_W'($urandom());
      f.minute = MIN_W'($urandom());
      f.hour   = HOUR_W'($urandom());
      f.day    = DAY_W'($urandom());
      f.month  = MONTH_W'($urandom());
      f.year   = YEAR_W'($urandom());
      return f;
   endfunction

   // A time a few seconds short of a carry, now and then with one field out of range
   function automatic cal_fields_type boundary_fields();
      cal_fields_type f;
      int y;
      int mo;
      int last;
      case ($urandom_range(0, 5))
         0:       y = 2000;
         1:       y = 1900;
         2:       y = 9999;
         3:       y = 4 * $urandom_range(0, 2499);
         4:       y = $urandom_range(0, 9999);
         default: y = 100 * $urandom_range(0, 99);
      endcase
      mo = ($urandom_range(0, 2) == 0) ? 2 : ($urandom_range(0, 1) ? 12 : $urandom_range(1, 12));
      last = days_in(mo, y);
      f.year   = YEAR_W'(y);
      f.month  = MONTH_W'(mo);
      f.day    = DAY_W'($urandom_range(0, 1) ? last : $urandom_range(1, last));
      f.hour   = HOUR_W'($urandom_range(0, 3) ? 23 : $urandom_range(0, 23));
      f.minute = MIN_W'($urandom_range(0, 3) ? 59 : $urandom_range(0, 59));
      f.second = SEC_W'($urandom_range(0, 3) ? 59 : $urandom_range(56, 59));
      case ($urandom_range(0, 15))
         0:       f.second = SEC_W'($urandom_range(60, 63));
         1:       f.minute = MIN_W'($urandom_range(60, 63));
         2:       f.hour   = HOUR_W'($urandom_range(24, 31));
         3:       f.day    = '0;
         4:       f.month  = MONTH_W'($urandom_range(0, 1) ? 0 : $urandom_range(13, 15));
         5:       f.year   = YEAR_W'($urandom_range(10000, 16383));
         default: ;
      endcase
      return f;
   endfunction

   task automatic report_error(string msg);
      error_count++;
      $display("ERROR cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic check_field(string name, int got, int want);
      if (got != want)
         report_error($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   // Drive one request beat; called and left at a falling edge
   task automatic send_beat(op_type op, cal_fields_type ld);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.operation   = op;
      req_bus.load_second = ld.second;
      req_bus.load_minute = ld.minute;
      req_bus.load_hour   = ld.hour;
      req_bus.load_day    = ld.day;
      req_bus.load_month  = ld.month;
      req_bus.load_year   = ld.year;
      req_bus.valid       = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      expected_times.push_back(next_calendar(op, ld));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_tick();
      send_beat(OP_TICK, rand_bits_fields());
   endtask

   task automatic run_to_count(int target);
      while (tick_count != target) send_tick();
   endtask

   task automatic wait_idle();
      req_bus.valid = 1'b0;
      while (expected_times.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = addr;
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      if (addr == ENABLE_ADDR) clock_enable = data[0];
   endtask

   task automatic check_enable_reg();
      logic [CSR_DATA_W-1:0] got;
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = ENABLE_ADDR;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      if (got != CSR_DATA_W'(clock_enable))
         report_error($sformatf("enable register read 0x%0h expected %0b", got, clock_enable));
   endtask

   task automatic test_reset_state();
      check_enable_reg();
      send_tick();
   endtask

   task automatic test_load_extremes();
      send_beat(OP_LOAD, make_time(0, 0, 0, 0, 0, 0));
      send_beat(OP_LOAD, make_time(63, 63, 31, 31, 15, 16383));
      send_beat(OP_LOAD, make_time(59, 59, 23, 31, 12, 9999));
      send_beat(OP_LOAD, make_time(0, 0, 0, 1, 1, 0));
      send_tick();
   endtask

   task automatic test_carry_chain();
      cal_fields_type cases[8];
      cases[0] = make_time(59, 0, 0, 1, 1, 1980);
      cases[1] = make_time(59, 59, 23, 31, 12, 9999);
      cases[2] = make_time(59, 59, 23, 28, 2, 2000);
      cases[3] = make_time(59, 59, 23, 28, 2, 1900);
      cases[4] = make_time(59, 59, 23, 29, 2, 2024);
      cases[5] = make_time(63, 63, 31, 31, 15, 16383);
      cases[6] = make_time(59, 59, 23, 30, 0, 2023);
      cases[7] = make_time(59, 59, 23, 0, 4, 2023);
      foreach (cases[i]) begin
         // Park the prescaler one short so the load is followed by the pulse
         run_to_count(TICKS_PER_SECOND - 1);
         send_beat(OP_LOAD, cases[i]);
         send_tick();
      end
   endtask

   task automatic test_clock_disable();
      wait_idle();
      csr_write(ENABLE_ADDR, 32'hFFFF_FFFE);
      check_enable_reg();
      run_to_count(TICKS_PER_SECOND - 2);
      send_beat(OP_LOAD, make_time(59, 59, 23, 31, 12, 9999));
      send_tick();
      send_tick();
      wait_idle();
      // Nothing lives at the spare word: the clock must stay stopped
      csr_write(SPARE_ADDR, 32'hFFFF_FFFF);
      check_enable_reg();
      run_to_count(TICKS_PER_SECOND - 1);
      send_tick();
      wait_idle();
      csr_write(ENABLE_ADDR, 32'hFFFF_FFFF);
      check_enable_reg();
      run_to_count(TICKS_PER_SECOND - 1);
      send_tick();
   endtask

   task automatic test_backpressure();
      req_gap_max     = 0;
      rsp_hold_cycles = 300;
      repeat (40) begin
         if ($urandom_range(0, 3) == 0) send_beat(OP_LOAD, boundary_fields());
         else send_tick();
      end
      req_gap_max = 16;
   endtask

   // Fill up the run to the item target
   task automatic test_random_traffic();
      int pick;
      logic [CSR_DATA_W-1:0] data;
      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 19);
         if (pick <= 11) begin
            run_to_count($urandom_range(TICKS_PER_SECOND - 3, TICKS_PER_SECOND - 1));
            send_beat(OP_LOAD, boundary_fields());
            repeat ($urandom_range(1, 4)) send_tick();
         end else if (pick <= 14) begin
            repeat ($urandom_range(1, 6)) send_beat(OP_LOAD, rand_bits_fields());
         end else if (pick <= 17) begin
            repeat ($urandom_range(1, 30)) send_tick();
         end else if (pick == 18) begin
            req_gap_max   = 8 * $urandom_range(0, 2);
            rsp_stall_max = 8 * $urandom_range(0, 2);
         end else begin
            wait_idle();
            data    = $urandom();
            data[0] = ($urandom_range(0, 3) != 0);
            csr_write($urandom_range(0, 3) ? ENABLE_ADDR : SPARE_ADDR, data);
            check_enable_reg();
         end
      end
      req_gap_max   = 16;
      rsp_stall_max = 16;
   endtask

   // Response side: stall at random, take each beat and compare it with the oldest expectation
   initial begin
      cal_result_type want;
      int stall;
      rsp_bus.ready = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = $urandom_range(0, rsp_stall_max);
         end
         if (stall > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         if (expected_times.size() == 0) begin
            report_error("response beat with nothing expected");
         end else begin
            want = expected_times.pop_front();
            check_field("second", rsp_bus.second, want.fields.second);
            check_field("minute", rsp_bus.minute, want.fields.minute);
            check_field("hour", rsp_bus.hour, want.fields.hour);
            check_field("day", rsp_bus.day, want.fields.day);
            check_field("month", rsp_bus.month, want.fields.month);
            check_field("year", rsp_bus.year, want.fields.year);
            check_field("second_pulse", rsp_bus.second_pulse, want.second_pulse);
         end
         @(negedge clock);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      reset           = 1'b1;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      req_bus.valid       = 1'b0;
      req_bus.operation   = OP_TICK;
      req_bus.load_second = '0;
      req_bus.load_minute = '0;
      req_bus.load_hour   = '0;
      req_bus.load_day    = '0;
      req_bus.load_month  = '0;
      req_bus.load_year   = '0;
      cal_now         = make_time(0, 0, 0, 1, 1, 1980);
      tick_count      = 0;
      clock_enable    = 1'b1;
      error_count     = 0;
      items_sent      = 0;
      req_gap_max     = 16;
      rsp_stall_max   = 16;
      rsp_hold_cycles = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_reset_state();
      test_load_extremes();
      test_carry_chain();
      test_clock_disable();
      test_backpressure();
      test_random_traffic();

      req_bus.valid = 1'b0;
      while (expected_times.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
